// ===== sv/dhfk_pkg.sv =====
// types, constants and helper functions shared by the forward kinematics block
package dhfk_pkg;

  localparam int unsigned NumLinks = 6;
  localparam int unsigned LinkW    = 60;
  localparam int unsigned JointW   = 16;
  localparam int unsigned RotW     = 18;
  localparam int unsigned PosW     = 24;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 240;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RotBase  = 0;
  localparam int unsigned PosBase  = 9 * RotW;
  localparam int unsigned PadLo    = PosBase + 3 * PosW;

  typedef logic signed [31:0] fx_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_e;

  typedef struct packed {
    fx_t   x;
    fx_t   y;
    fx_t   z;
    quad_e quad;
  } crd_t;

  typedef struct packed {
    fx_t c;
    fx_t s;
  } sc_t;

  // rotation or local transform, plus offset
  typedef struct {
    fx_t m [3][3];
    fx_t p [3];
  } xform_t;

  localparam fx_t CordicX0 = 32'sd652032874;
  localparam fx_t OneQ30   = 32'sd1073741824;

  localparam logic signed [23:0] PosMax = 24'sh7fffff;
  localparam logic signed [23:0] PosMin = 24'sh800000;

  function automatic fx_t atan_step(int unsigned i);
    fx_t v;
    case (i)
      0:       v = 32'sd536870912;
      1:       v = 32'sd316933406;
      2:       v = 32'sd167458907;
      3:       v = 32'sd85004756;
      4:       v = 32'sd42667331;
      5:       v = 32'sd21354465;
      6:       v = 32'sd10679838;
      7:       v = 32'sd5340245;
      8:       v = 32'sd2670163;
      9:       v = 32'sd1335087;
      10:      v = 32'sd667544;
      11:      v = 32'sd333772;
      12:      v = 32'sd166886;
      13:      v = 32'sd83443;
      14:      v = 32'sd41722;
      15:      v = 32'sd20861;
      16:      v = 32'sd10430;
      17:      v = 32'sd5215;
      18:      v = 32'sd2608;
      19:      v = 32'sd1304;
      20:      v = 32'sd652;
      21:      v = 32'sd326;
      22:      v = 32'sd163;
      23:      v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // nearest quarter turn and the remainder as the start vector
  function automatic crd_t angle_init(logic [31:0] ang);
    logic [31:0] t;
    logic [31:0] r;
    crd_t        c;
    t      = ang + 32'h2000_0000;
    r      = ang - {t[31:30], 30'd0};
    c.x    = CordicX0;
    c.y    = '0;
    c.z    = fx_t'(r);
    c.quad = quad_e'(t[31:30]);
    return c;
  endfunction

  function automatic sc_t resolve(crd_t v);
    sc_t r;
    case (v.quad)
      QUAD_0: begin
        r.c = v.x;
        r.s = v.y;
      end
      QUAD_90: begin
        r.c = -v.y;
        r.s = v.x;
      end
      QUAD_180: begin
        r.c = -v.x;
        r.s = -v.y;
      end
      QUAD_270: begin
        r.c = v.y;
        r.s = -v.x;
      end
      default: begin
        r.c = v.x;
        r.s = v.y;
      end
    endcase
    return r;
  endfunction

  function automatic fx_t round30(logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + (66'sd1 <<< 29);
    return fx_t'(t[61:30]);
  endfunction

  function automatic fx_t round22(logic signed [49:0] v);
    logic signed [49:0] t;
    t = v + (50'sd1 <<< 21);
    return {{4{t[49]}}, t[49:22]};
  endfunction

  function automatic logic [RotW-1:0] rot_out(fx_t r);
    fx_t t;
    t = r + 32'sd8192;
    return t[31:14];
  endfunction

  function automatic logic [PosW-1:0] pos_out(fx_t p);
    fx_t t;
    fx_t s;
    t = p + 32'sd8;
    s = t >>> 4;
    if (s > fx_t'(PosMax)) begin
      return PosMax;
    end else if (s < fx_t'(PosMin)) begin
      return PosMin;
    end
    return s[PosW-1:0];
  endfunction

endpackage

// ===== sv/dhfk_cordic_cell.sv =====
// one registered cordic micro-rotation
module dhfk_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  dhfk_pkg::crd_t crd_i,
  output dhfk_pkg::crd_t crd_o
);
  import dhfk_pkg::*;

  crd_t crd_d;
  crd_t crd_q;
  fx_t  xs;
  fx_t  ys;

  always_comb begin
    xs         = $signed(crd_i.x) >>> SHIFT;
    ys         = $signed(crd_i.y) >>> SHIFT;
    crd_d      = crd_i;
    if (!crd_i.z[31]) begin
      crd_d.x = crd_i.x - ys;
      crd_d.y = crd_i.y + xs;
      crd_d.z = crd_i.z - atan_step(SHIFT);
    end else begin
      crd_d.x = crd_i.x + ys;
      crd_d.y = crd_i.y - xs;
      crd_d.z = crd_i.z + atan_step(SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crd_q <= crd_d;
    end
  end

  assign crd_o = crd_q;

endmodule

// ===== sv/dhfk_link_cell.sv =====
// one link of the chain: pose times local transform, registered
module dhfk_link_cell #(
  parameter int unsigned LINK = 0,
  parameter int unsigned NJ   = 6
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  dhfk_pkg::xform_t pose_i,
  input  dhfk_pkg::xform_t loc_i [NJ],
  output dhfk_pkg::xform_t pose_o,
  output dhfk_pkg::xform_t loc_o [NJ]
);
  import dhfk_pkg::*;

  xform_t pose_d;
  xform_t pose_q;
  xform_t loc_q [NJ];

  always_comb begin
    logic signed [65:0] acc;
    logic signed [65:0] accp;
    for (int i = 0; i < 3; i++) begin
      accp = '0;
      for (int m = 0; m < 3; m++) begin
        accp = accp + pose_i.m[i][m] * loc_i[LINK].p[m];
      end
      pose_d.p[i] = pose_i.p[i] + round30(accp);
      for (int j = 0; j < 3; j++) begin
        acc = '0;
        for (int m = 0; m < 3; m++) begin
          acc = acc + pose_i.m[i][m] * loc_i[LINK].m[m][j];
        end
        pose_d.m[i][j] = round30(acc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pose_q <= pose_d;
      loc_q  <= loc_i;
    end
  end

  assign pose_o = pose_q;
  assign loc_o  = loc_q;

endmodule

// ===== sv/dh_forward_kinematics_6dof.sv =====
// top level: six-axis forward kinematics pipeline, modified dh convention
//
// s_axis carries one item of six joint angles, m_axis returns the tool pose
// (3x3 rotation in Q2.16, xyz in 1/16 mm, saturated). Link parameters are
// written through cfg_we_i / cfg_idx_i / cfg_data_i, one 60-bit word per link.
// Every input item gives exactly one result item.
// Pipeline: the cordic micro-rotation cells, a register for the local link
// transforms, the link cells, then the output register.
// Throughput: one item per cycle while the output is not stalled; every cell
// takes new data whenever the pipeline advances.
// Stall: when the result waits in the output register, the pipeline still
// advances while its last stage is empty; once that stage holds a result
// too, the whole pipeline and s_axis_tready hold until m_axis_tready.
// Reset: clears the link parameters to zero and empties the pipeline.
module dh_forward_kinematics_6dof #(
  parameter int unsigned NUM_JOINTS    = 6,
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // joint_angle_1 .. joint_angle_6
  input  logic [dhfk_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx, rot_zy, rot_zz,
  // pos_x, pos_y, pos_z, zero pad
  output logic [dhfk_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [dhfk_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dhfk_pkg::LinkW-1:0]      cfg_data_i
);
  import dhfk_pkg::*;

  localparam int unsigned Depth = CORDIC_STAGES + 1 + NUM_JOINTS;
  localparam int unsigned Lanes = 2 * NUM_JOINTS;
  localparam logic [31:0] AngMask = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic [LinkW-1:0]    link_q [NumLinks];
  logic [Depth-1:0]    vld_q;
  logic [Depth-1:0]    vld_d;
  logic                m_valid_q;
  logic                m_valid_d;
  logic [OutDataW-1:0] m_data_q;
  logic [OutDataW-1:0] m_data_d;
  logic                out_free;
  logic                adv;

  crd_t   crd        [Lanes][CORDIC_STAGES+1];
  xform_t locs       [NUM_JOINTS+1][NUM_JOINTS];
  xform_t pose_chain [NUM_JOINTS+1];
  xform_t pose_id;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumLinks; k++) begin
        link_q[k] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumLinks))) begin
      link_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // flow control
  assign out_free      = !m_valid_q || m_axis_tready;
  assign adv           = !vld_q[Depth-1] || out_free;
  assign s_axis_tready = adv;
  assign vld_d         = {vld_q[Depth-2:0], s_axis_tvalid};
  assign m_valid_d     = out_free ? vld_q[Depth-1] : m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= vld_d;
      end
      m_valid_q <= m_valid_d;
    end
  end

  // sine and cosine lanes, then local transforms
  for (genvar k = 0; k < NUM_JOINTS; k++) begin : g_link
    logic [11:0] alpha;
    logic [11:0] offs;
    logic [31:0] theta_ang;
    logic [31:0] alpha_ang;
    xform_t      loc_d;
    xform_t      loc_q;

    assign alpha     = link_q[k][59:48];
    assign offs      = link_q[k][47:36];
    assign theta_ang = ({s_axis_tdata[k*JointW +: JointW], 16'd0} + {offs, 20'd0}) & AngMask;
    assign alpha_ang = {alpha, 20'd0} & AngMask;
    assign crd[2*k][0]   = angle_init(theta_ang);
    assign crd[2*k+1][0] = angle_init(alpha_ang);

    always_comb begin
      sc_t                th;
      sc_t                al;
      logic signed [65:0] pr;
      logic signed [49:0] pd;
      logic signed [17:0] a_mm;
      logic signed [17:0] d_mm;
      th   = resolve(crd[2*k][CORDIC_STAGES]);
      al   = resolve(crd[2*k+1][CORDIC_STAGES]);
      a_mm = link_q[k][35:18];
      d_mm = link_q[k][17:0];
      loc_d.m[0][0] = th.c;
      loc_d.m[0][1] = -th.s;
      loc_d.m[0][2] = '0;
      pr = al.c * th.s;
      loc_d.m[1][0] = round30(pr);
      pr = al.c * th.c;
      loc_d.m[1][1] = round30(pr);
      loc_d.m[1][2] = -al.s;
      pr = al.s * th.s;
      loc_d.m[2][0] = round30(pr);
      pr = al.s * th.c;
      loc_d.m[2][1] = round30(pr);
      loc_d.m[2][2] = al.c;
      loc_d.p[0]    = {{6{a_mm[17]}}, a_mm, 8'd0};
      pd = -al.s * d_mm;
      loc_d.p[1] = round22(pd);
      pd = al.c * d_mm;
      loc_d.p[2] = round22(pd);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        loc_q <= loc_d;
      end
    end

    assign locs[0][k] = loc_q;
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      dhfk_cordic_cell #(
        .SHIFT (s)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .crd_i (crd[l][s]),
        .crd_o (crd[l][s+1])
      );
    end
  end

  // identity base frame
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pose_id.p[i] = '0;
      for (int j = 0; j < 3; j++) begin
        pose_id.m[i][j] = (i == j) ? OneQ30 : '0;
      end
    end
  end

  assign pose_chain[0] = pose_id;

  for (genvar k = 0; k < NUM_JOINTS; k++) begin : g_chain
    dhfk_link_cell #(
      .LINK (k),
      .NJ   (NUM_JOINTS)
    ) u_link (
      .clk_i  (clk_i),
      .en_i   (adv),
      .pose_i (pose_chain[k]),
      .loc_i  (locs[k]),
      .pose_o (pose_chain[k+1]),
      .loc_o  (locs[k+1])
    );
  end

  // output rounding and packing
  always_comb begin
    m_data_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_data_d[RotBase + (i*3+j)*RotW +: RotW] = rot_out(pose_chain[NUM_JOINTS].m[i][j]);
      end
      m_data_d[PosBase + i*PosW +: PosW] = pos_out(pose_chain[NUM_JOINTS].p[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== sv/dhfk_checker.sv =====
// port checker for the forward kinematics block, bound to the top level
module dhfk_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dhfk_pkg::OutDataW-1:0]  m_axis_tdata
);
  import dhfk_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:PadLo] == '0)
    else $error("pad bits of result not zero");

endmodule

bind dh_forward_kinematics_6dof dhfk_checker u_dhfk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
